@@ rtl/core/was_pkg.sv @@
`default_nettype none
package was_pkg;
    localparam int TABLE_ENTRIES = 128;
    localparam int ENTRY_W = 17;
    localparam int VALUE_W = 24;
    localparam int RATE_W = 16;
    localparam logic [ENTRY_W-1:0] ENTRY_MAX = 17'h1FFFF;

    localparam logic [1:0] KIND_DRAW = 2'd0;
    localparam logic [1:0] KIND_POLICY = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [0:0] REG_LEARNING_ENABLED = 1'd0;
    localparam logic [0:0] REG_LEARNING_RATE = 1'd1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [16:0]        random_draw;
        logic [16:0]        action_position;
        logic signed [23:0] reward;
        logic signed [23:0] target_value;
    } in_item_t;

    typedef struct packed {
        logic [6:0]         selected_index;
        logic [16:0]        confidence;
        logic signed [23:0] value_estimate;
    } out_item_t;

    // round(rate * x / 65536) half up, x a signed 25-bit value
    function automatic logic signed [25:0] scale_by_rate(input logic [15:0] rate,
                                                         input logic signed [24:0] x);
        logic signed [42:0] p;
        begin
            p = $signed({1'b0, rate}) * x + 43'sd32768;
            scale_by_rate = 26'(p >>> 16);
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/was_ram.sv @@
`default_nettype none
module was_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/was_div.sv @@
`default_nettype none
// Restoring divider: quotient = num / den, one bit per cycle
module was_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 30
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DEN_W+1:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[NUM_W-1]} - {2'b0, d_reg};
        if (start)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
            cnt_next = CW'(NUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[DEN_W+1])
            begin
                r_next = trial[DEN_W:0];
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

@@ rtl/core/weighted_action_sampler_unit.sv @@
`default_nettype none
// Roulette-wheel action sampler. The policy table sits in one single-port-read RAM
// and a draw walks it one entry per cycle. A policy update rewrites the chosen
// entry, walks the table once to sum it and then renormalizes each entry through
// the bit-serial divider, which holds the walk until its quotient is done (no
// renormalizing pass when the table sum is zero); a value update does not walk
// the table. After reset a clearing pass loads the uniform probability into every
// entry, with busy high. Assert start only while busy is low; each item yields
// exactly one result, shown for one cycle with done high, and the receiver cannot
// hold it off.
module weighted_action_sampler_unit #(
    parameter int TABLE_ENTRIES = was_pkg::TABLE_ENTRIES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire was_pkg::in_item_t in_item,
    output logic                   done,
    output was_pkg::out_item_t     out_item,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_index,
    input  wire logic [15:0]       cfg_data
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int SW = was_pkg::ENTRY_W + AW + 1;
    localparam int NW = was_pkg::ENTRY_W + 16 + 1;
    localparam logic [was_pkg::ENTRY_W-1:0] UNIFORM = was_pkg::ENTRY_W'(65536 / TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_DRAW   = 11'b00000000100,
        S_CONF   = 11'b00000001000,
        S_UPRD   = 11'b00000010000,
        S_UPWR   = 11'b00000100000,
        S_SUM    = 11'b00001000000,
        S_NRD    = 11'b00010000000,
        S_NDIV   = 11'b00100000000,
        S_NWR    = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [AW-1:0] sel_reg, sel_next;
    logic found_reg, found_next;
    logic [16:0] conf_reg, conf_next;
    logic signed [23:0] value_reg, value_next;
    logic enabled_reg, enabled_next;
    logic [15:0] rate_reg, rate_next;
    was_pkg::in_item_t item_reg, item_next;
    logic done_reg, done_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [was_pkg::ENTRY_W-1:0] wdata, rdata;
    logic div_start, div_done;
    logic [NW-1:0] div_q;
    logic [NW-1:0] div_num;

    was_ram #(.WIDTH(was_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign div_num = (NW'(rdata) << 16) + NW'(sum_reg >> 1);

    was_div #(.NUM_W(NW), .DEN_W(SW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(sum_reg), .done(div_done), .quotient(div_q)
    );

    logic [AW+16:0] idx_prod;
    logic [AW-1:0] upd_idx;
    logic signed [25:0] delta;
    logic signed [26:0] e_new;
    logic [SW-1:0] cum;
    logic signed [25:0] vsum;
    logic signed [25:0] vdelta;

    always_comb
    begin
        idx_prod = (AW+17)'(item_reg.action_position) * (AW+17)'(TABLE_ENTRIES);
        upd_idx = ((idx_prod >> 16) >= (AW+17)'(TABLE_ENTRIES)) ? LAST
                  : AW'(idx_prod >> 16);
        delta = was_pkg::scale_by_rate(rate_reg, 25'(item_reg.reward));
        e_new = 27'($signed({1'b0, rdata})) + 27'(delta);
        cum = sum_reg + SW'(rdata);
        vdelta = was_pkg::scale_by_rate(rate_reg,
                 25'(item_reg.target_value) - 25'(value_reg));
        vsum = 26'(value_reg) + vdelta;
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        sel_next = sel_reg;
        found_next = found_reg;
        conf_next = conf_reg;
        value_next = value_reg;
        enabled_next = enabled_reg;
        rate_next = rate_reg;
        item_next = item_reg;
        done_next = 1'b0;
        we = 1'b0;
        waddr = addr_reg;
        wdata = rdata;
        raddr = addr_reg;
        div_start = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == 16'(was_pkg::REG_LEARNING_ENABLED))
            begin
                enabled_next = cfg_data[0];
            end
            else if (cfg_index == 16'(was_pkg::REG_LEARNING_RATE))
            begin
                rate_next = cfg_data;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wdata = UNIFORM;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = in_item;
                    addr_next = '0;
                    raddr = '0;
                    cnt_next = '0;
                    sum_next = '0;
                    sel_next = '0;
                    found_next = 1'b0;
                    conf_next = '0;
                    if (in_item.kind == was_pkg::KIND_DRAW)
                    begin
                        state_next = S_DRAW;
                    end
                    else if (in_item.kind == was_pkg::KIND_POLICY && enabled_reg)
                    begin
                        state_next = S_UPRD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DRAW:
            begin
                // rdata holds entry cnt
                sum_next = cum;
                if (!found_reg && SW'(item_reg.random_draw) <= cum)
                begin
                    found_next = 1'b1;
                    sel_next = cnt_reg[AW-1:0];
                end
                raddr = cnt_reg[AW-1:0] + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_CONF;
                    raddr = (!found_reg && SW'(item_reg.random_draw) <= cum)
                            ? cnt_reg[AW-1:0] : (found_reg ? sel_reg : '0);
                end
            end
            S_CONF:
            begin
                if (!found_reg)
                begin
                    sel_next = '0;
                end
                raddr = found_reg ? sel_reg : '0;
                state_next = S_OUT;
            end
            S_UPRD:
            begin
                raddr = upd_idx;
                state_next = S_UPWR;
            end
            S_UPWR:
            begin
                we = 1'b1;
                waddr = upd_idx;
                if (e_new < 0)
                begin
                    wdata = '0;
                end
                else if (e_new > 27'sd131071)
                begin
                    wdata = was_pkg::ENTRY_MAX;
                end
                else
                begin
                    wdata = 17'(e_new);
                end
                raddr = '0;
                cnt_next = '0;
                sum_next = '0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // a gap step after the write re-reads entry 0 and keeps the read of that entry current
                if (cnt_reg != '0 || addr_reg == '1)
                begin
                    sum_next = cum;
                end
                addr_next = '1;
                raddr = cnt_reg[AW-1:0] + ((cnt_reg == '0 && addr_reg != '1) ? 1'b0 : 1'b1);
                if (cnt_reg == '0 && addr_reg != '1)
                begin
                    raddr = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == (AW+1)'(TABLE_ENTRIES - 1))
                    begin
                        cnt_next = '0;
                        raddr = '0;
                        state_next = (cum == '0) ? S_OUT : S_NRD;
                    end
                end
            end
            S_NRD:
            begin
                raddr = cnt_reg[AW-1:0];
                div_start = 1'b1;
                state_next = S_NDIV;
            end
            S_NDIV:
            begin
                raddr = cnt_reg[AW-1:0];
                if (div_done)
                begin
                    state_next = S_NWR;
                end
            end
            S_NWR:
            begin
                we = 1'b1;
                waddr = cnt_reg[AW-1:0];
                wdata = was_pkg::ENTRY_W'(div_q);
                cnt_next = cnt_reg + 1'b1;
                raddr = cnt_reg[AW-1:0] + 1'b1;
                state_next = (cnt_reg == (AW+1)'(TABLE_ENTRIES - 1)) ? S_OUT : S_NRD;
            end
            S_OUT:
            begin
                if (item_reg.kind == was_pkg::KIND_DRAW)
                begin
                    conf_next = rdata;
                end
                else if (item_reg.kind == was_pkg::KIND_VALUE && enabled_reg)
                begin
                    if (vsum > 26'sd8388607)
                    begin
                        value_next = 24'sh7FFFFF;
                    end
                    else if (vsum < -26'sd8388608)
                    begin
                        value_next = 24'sh800000;
                    end
                    else
                    begin
                        value_next = 24'(vsum);
                    end
                end
                addr_next = '0;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg <= '0;
            cnt_reg <= '0;
            found_reg <= 1'b0;
            value_reg <= '0;
            enabled_reg <= 1'b1;
            rate_reg <= 16'd655;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            cnt_reg <= cnt_next;
            found_reg <= found_next;
            value_reg <= value_next;
            enabled_reg <= enabled_next;
            rate_reg <= rate_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        sel_reg <= sel_next;
        conf_reg <= conf_next;
        item_reg <= item_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign out_item.selected_index = 7'(sel_reg);
    assign out_item.confidence = conf_reg;
    assign out_item.value_estimate = value_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_done_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_OUT) else $error("result without output step");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted transaction left block idle");
endmodule
`default_nettype wire
